// ===== rtl/core/cte_pkg.sv =====
package cte_pkg;

    localparam logic [1:0] ACT_STORE  = 2'd0;
    localparam logic [1:0] ACT_HEADER = 2'd1;
    localparam logic [1:0] ACT_PIXEL  = 2'd2;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    localparam int PAL_WORDS      = 256;
    localparam int PAL_STEP_SHIFT = 6;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;
    localparam int CNT_W          = 25;

    localparam logic [7:0] SWAP_MASK = 8'h18;
    localparam logic [7:0] ALPHA_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_HEADER = 2'd1,
        OP_PIXEL  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2,
        ST_PALETTE = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        t_status          status;
        logic [CNT_W-1:0] count;
        logic [14:0]      pal;
        logic [13:0]      addr;
        logic [31:0]      word;
        logic [7:0]       pix;
    } t_cmd;

    function automatic logic [7:0] swap_middle(input logic [7:0] idx);
        swap_middle = (idx[4] != idx[3]) ? (idx ^ SWAP_MASK) : idx;
    endfunction

endpackage

// ===== rtl/core/cte_ram.sv =====
module cte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cte_front.sv =====
module cte_front #(
    parameter int STORE_WORDS = 16384,
    parameter int MAX_SIDE    = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [135:0]  i_tdata,
    input  logic [1:0]    i_tuser,
    input  logic [31:0]   i_texture_base,
    input  logic [35:0]   i_data_size,
    input  logic          i_full,
    output logic          o_push,
    output cte_pkg::t_cmd o_cmd
);
    import cte_pkg::*;

    logic [13:0] f_addr;
    logic [31:0] f_word;
    logic [31:0] f_off;
    logic [15:0] f_w;
    logic [15:0] f_h;
    logic [15:0] f_pal;
    logic [7:0]  f_pix;
    logic        keep;
    logic        bad;
    logic [25:0] prod;
    logic [32:0] poff;
    logic        adv;
    t_op         op;

    logic             r_valid;
    t_op              r_op;
    logic             r_invalid;
    logic [CNT_W-1:0] r_count;
    logic [32:0]      r_poff;
    logic [14:0]      r_pal;
    logic [13:0]      r_addr;
    logic [31:0]      r_word;
    logic [7:0]       r_pix;

    logic [35:0] span_end;
    logic [31:0] pal_end;
    t_status     status;

    assign f_addr = i_tdata[13:0];
    assign f_word = i_tdata[45:14];
    assign f_off  = i_tdata[77:46];
    assign f_w    = i_tdata[93:78];
    assign f_h    = i_tdata[109:94];
    assign f_pal  = i_tdata[125:110];
    assign f_pix  = i_tdata[133:126];

    always_comb begin
        case (i_tuser)
            ACT_STORE: begin
                op   = OP_STORE;
                keep = 32'(f_addr) < 32'(STORE_WORDS);
            end
            ACT_HEADER: begin
                op   = OP_HEADER;
                keep = 1'b1;
            end
            ACT_PIXEL: begin
                op   = OP_PIXEL;
                keep = 1'b1;
            end
            default: begin
                op   = OP_PIXEL;
                keep = 1'b0;
            end
        endcase
    end

    assign bad = f_off[31] || f_w[15] || f_h[15] || f_pal[15]
              || (f_w == 16'd0) || (f_h == 16'd0)
              || (f_w > 16'(MAX_SIDE)) || (f_h > 16'(MAX_SIDE));
    assign prod = f_w[12:0] * f_h[12:0];
    assign poff = {1'b0, i_texture_base} + {1'b0, f_off};

    assign adv      = !r_valid || !i_full;
    assign o_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_tvalid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_tvalid) begin
            r_op      <= op;
            r_invalid <= bad;
            r_count   <= prod[CNT_W-1:0];
            r_poff    <= poff;
            r_pal     <= f_pal[14:0];
            r_addr    <= f_addr;
            r_word    <= f_word;
            r_pix     <= swap_middle(f_pix);
        end
    end

    // header checks: pixel span against data size, palette span against store
    assign span_end = 36'(r_poff) + 36'(r_count);
    assign pal_end  = {11'd0, r_pal, 6'd0} + 32'(PAL_WORDS);

    always_comb begin
        if (r_invalid) begin
            status = ST_INVALID;
        end else if (span_end > i_data_size) begin
            status = ST_RANGE;
        end else if (pal_end > 32'(STORE_WORDS)) begin
            status = ST_PALETTE;
        end else begin
            status = ST_OK;
        end
    end

    assign o_push       = r_valid && !i_full;
    assign o_cmd.op     = r_op;
    assign o_cmd.status = status;
    assign o_cmd.count  = r_count;
    assign o_cmd.pal    = r_pal;
    assign o_cmd.addr   = r_addr;
    assign o_cmd.word   = r_word;
    assign o_cmd.pix    = r_pix;

endmodule

// ===== rtl/core/cte_queue.sv =====
module cte_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cte_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cte_pkg::t_cmd o_head
);
    import cte_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/cte_back.sv =====
module cte_back #(
    parameter int STORE_WORDS = 16384
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  cte_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [39:0]   o_m_tdata,
    output logic          o_m_tuser,
    output logic          o_m_tlast
);
    import cte_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);

    logic          adv_out;
    logic          adv2;
    logic          live_pix;
    logic          produce;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] rd_addr;
    logic [31:0]   ram_q;
    logic [7:0]    a2;
    logic          a_low;

    logic [CNT_W-1:0] r_left;
    logic [AW-1:0]    r_pal_base;
    logic             r_alpha_seen;

    logic    r_s2_valid;
    logic    r_s2_kind;
    t_status r_s2_status;
    logic    r_s2_last;
    logic    r_s2_open;

    logic        r_o_valid;
    logic        r_o_kind;
    logic        r_o_last;
    logic [39:0] r_o_data;

    assign adv_out  = !r_o_valid || i_m_tready;
    assign adv2     = !r_s2_valid || adv_out;
    assign o_pop    = i_cmd_valid && adv2;
    assign live_pix = (i_cmd.op == OP_PIXEL) && (r_left != '0);
    assign produce  = o_pop && ((i_cmd.op == OP_HEADER) || live_pix);
    assign ram_we   = o_pop && (i_cmd.op == OP_STORE);
    assign ram_re   = o_pop && live_pix;
    assign rd_addr  = r_pal_base + AW'(i_cmd.pix);

    cte_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_cmd.addr)),
        .i_wdata (i_cmd.word),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_pal_base <= '0;
        end else if (o_pop) begin
            case (i_cmd.op)
                OP_HEADER: begin
                    if (i_cmd.status == ST_OK) begin
                        r_left     <= i_cmd.count;
                        r_pal_base <= AW'({i_cmd.pal, {PAL_STEP_SHIFT{1'b0}}});
                    end else begin
                        r_left <= '0;
                    end
                end
                OP_PIXEL: begin
                    if (live_pix) begin
                        r_left <= r_left - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv2) begin
            r_s2_valid <= produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && produce) begin
            r_s2_kind   <= (i_cmd.op == OP_PIXEL) ? KIND_PIXEL : KIND_HEADER;
            r_s2_status <= (i_cmd.op == OP_PIXEL) ? ST_OK : i_cmd.status;
            r_s2_last   <= (i_cmd.op == OP_PIXEL) && (r_left == CNT_W'(1));
            r_s2_open   <= (i_cmd.op == OP_HEADER) && (i_cmd.status == ST_OK);
        end
    end

    // alpha doubled, saturating
    assign a2    = ram_q[31] ? ALPHA_MAX : {ram_q[30:24], 1'b0};
    assign a_low = a2 != ALPHA_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_alpha_seen <= 1'b0;
        end else if (adv_out) begin
            r_o_valid <= r_s2_valid;
            if (r_s2_valid) begin
                if (r_s2_kind == KIND_PIXEL) begin
                    r_alpha_seen <= r_alpha_seen || a_low;
                end else if (r_s2_open) begin
                    r_alpha_seen <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s2_valid) begin
            r_o_kind <= r_s2_kind;
            if (r_s2_kind == KIND_PIXEL) begin
                r_o_last <= r_s2_last;
                r_o_data <= {5'd0, r_s2_last && (r_alpha_seen || a_low), a2,
                             ram_q[23:0], ST_OK};
            end else begin
                r_o_last <= 1'b0;
                r_o_data <= {38'd0, r_s2_status};
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

endmodule

// ===== rtl/core/clut8_texture_expander.sv =====
// 8-bit indexed texture expander. Input beats carry a store write, a texture
// header or a pixel index (tuser selects). Headers are answered with a status
// beat; each pixel of an open texture yields one RGBA beat, the final one with
// tlast. One input beat per cycle is sustained while the queue has room; a
// header or pixel result passes through the input register and header checks,
// a four-entry command queue, the color store read, and the output register.
// The color store is a single-port-write, single-port-read memory of
// STORE_WORDS words; it is not cleared, so only written words may be read.
module clut8_texture_expander #(
    parameter int STORE_WORDS = 16384,
    parameter int MAX_SIDE    = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // store_address, store_word, data_offset, width_raw, height_raw,
    // palette_raw, pixel, zero pad
    input  logic [135:0] i_s_tdata,
    // action
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status, red, green, blue, alpha, has_alpha, zero pad
    output logic [39:0]  o_m_tdata,
    // kind
    output logic         o_m_tuser,
    output logic         o_m_tlast,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [63:0]  i_pwdata,
    output logic [63:0]  o_prdata,
    output logic         o_pready
);
    import cte_pkg::*;

    logic [31:0] r_texture_base;
    logic [35:0] r_data_size;
    logic        cfg_we;

    logic push;
    logic full;
    logic pop;
    logic head_valid;
    t_cmd cmd_in;
    t_cmd cmd_head;

    assign o_pready = 1'b1;
    assign cfg_we   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata = i_paddr[3] ? {28'd0, r_data_size} : {32'd0, r_texture_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_texture_base <= '0;
            r_data_size    <= '0;
        end else if (cfg_we) begin
            if (i_paddr[3]) begin
                r_data_size <= i_pwdata[35:0];
            end else begin
                r_texture_base <= i_pwdata[31:0];
            end
        end
    end

    cte_front #(
        .STORE_WORDS (STORE_WORDS),
        .MAX_SIDE    (MAX_SIDE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tvalid       (i_s_tvalid),
        .o_tready       (o_s_tready),
        .i_tdata        (i_s_tdata),
        .i_tuser        (i_s_tuser),
        .i_texture_base (r_texture_base),
        .i_data_size    (r_data_size),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (cmd_in)
    );

    cte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (cmd_head)
    );

    cte_back #(
        .STORE_WORDS (STORE_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (cmd_head),
        .o_pop       (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== rtl/core/cte_checker.sv =====
module cte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);
    import cte_pkg::*;

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("result beat dropped or changed under stall");

    a_header_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_HEADER) |-> !o_m_tlast
            && (o_m_tdata[39:2] == '0))
        else $error("header status beat carries color or last");

    a_pixel_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_PIXEL) |-> o_m_tdata[1:0] == ST_OK)
        else $error("pixel beat carries nonzero status");

    a_alpha_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_m_tdata[34] && (o_m_tdata[39:35] == '0))
        else $error("has_alpha set before the final pixel");

endmodule

bind clut8_texture_expander cte_checker u_cte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
